@@ rtl/kpd_pkg.sv @@
// Shared types and constants for the keypad debounce and long-press detector.
package kpd_pkg;

  localparam int MAP_W     = 16;
  localparam int IDX_W     = 4;
  localparam int DB_W      = 8;
  localparam int HOLD_W    = 16;
  localparam int DUR_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 1'b1;

  localparam logic [DB_W-1:0]   DEBOUNCE_RST = 8'd2;
  localparam logic [HOLD_W-1:0] LONG_RST     = 16'd100;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_LONG    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_LONG    = 2'd2,
    EV_RELEASE = 2'd3
  } evt_kind_t;

  // Per-key status toward the event selector.
  typedef struct packed {
    evt_kind_t         kind;
    logic              held;
    logic [DUR_W-1:0]  held_ticks;
  } key_evt_t;

  // Ticks to milliseconds, 10 ms per tick, wrapped to 16 bits.
  function automatic logic [DUR_W-1:0] ticks_to_ms(input logic [DUR_W-1:0] t);
    ticks_to_ms = (t << 3) + (t << 1);
  endfunction

endpackage

@@ rtl/kpd_key.sv @@
// Debounce and long-press state machine for one key.
module kpd_key
  import kpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              pressed,
  input  logic [DB_W-1:0]   debounce_ticks,
  input  logic [HOLD_W-1:0] long_press_ticks,
  input  logic [DUR_W-1:0]  tick,
  output key_evt_t          evt
);

  phase_t              phase_r, phase_nxt;
  logic [DB_W-1:0]     db_cnt_r, db_cnt_nxt;
  logic [HOLD_W-1:0]   hold_cnt_r, hold_cnt_nxt;
  logic [DUR_W-1:0]    stamp_r, stamp_nxt;

  logic [DB_W:0]       db_inc;
  logic [HOLD_W:0]     hold_inc;
  logic                db_hit;
  logic                hold_hit;

  assign db_inc   = {1'b0, db_cnt_r} + {{DB_W{1'b0}}, 1'b1};
  assign hold_inc = {1'b0, hold_cnt_r} + {{HOLD_W{1'b0}}, 1'b1};
  assign db_hit   = db_inc >= {1'b0, debounce_ticks};
  assign hold_hit = hold_inc >= {1'b0, long_press_ticks};

  // Next state
  always_comb begin
    phase_nxt    = phase_r;
    db_cnt_nxt   = db_cnt_r;
    hold_cnt_nxt = hold_cnt_r;
    stamp_nxt    = stamp_r;
    case (phase_r)
      PH_IDLE: begin
        if (pressed) begin
          if (db_hit) begin
            phase_nxt  = PH_PRESS;
            db_cnt_nxt = '0;
            stamp_nxt  = tick;
          end else begin
            db_cnt_nxt = db_inc[DB_W-1:0];
          end
        end else begin
          db_cnt_nxt = '0;
        end
      end
      PH_PRESS: begin
        if (pressed) begin
          if (hold_hit) begin
            phase_nxt    = PH_LONG;
            hold_cnt_nxt = '0;
          end else begin
            hold_cnt_nxt = hold_inc[HOLD_W-1:0];
          end
        end else begin
          phase_nxt    = PH_RELEASE;
          hold_cnt_nxt = '0;
        end
      end
      PH_LONG: begin
        if (!pressed) phase_nxt = PH_RELEASE;
      end
      PH_RELEASE: begin
        if (!pressed) begin
          if (db_hit) begin
            phase_nxt  = PH_IDLE;
            db_cnt_nxt = '0;
          end else begin
            db_cnt_nxt = db_inc[DB_W-1:0];
          end
        end else begin
          // bounce back: keep the original press stamp
          db_cnt_nxt = '0;
          phase_nxt  = PH_PRESS;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    evt.kind       = EV_NONE;
    evt.held       = (phase_nxt == PH_PRESS) || (phase_nxt == PH_LONG);
    evt.held_ticks = tick - stamp_r;
    case (phase_r)
      PH_IDLE:    if (pressed && db_hit)    evt.kind = EV_PRESS;
      PH_PRESS:   if (pressed && hold_hit)  evt.kind = EV_LONG;
      PH_LONG:    evt.kind = EV_NONE;
      PH_RELEASE: if (!pressed && db_hit)   evt.kind = EV_RELEASE;
      default:    evt.kind = EV_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      db_cnt_r   <= '0;
      hold_cnt_r <= '0;
      stamp_r    <= '0;
    end else if (en) begin
      phase_r    <= phase_nxt;
      db_cnt_r   <= db_cnt_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      stamp_r    <= stamp_nxt;
    end
  end

endmodule

@@ rtl/keypad_debounce_long_press.sv @@
// Keypad debounce and long-press detector: one scan tick in, one event item out per tick.
// Each input item is one 10 ms scan tick carrying the pressed bitmap of up to sixteen keys;
// every tick yields exactly one result item with the winning event (highest key index on a
// tie), the raw any-pressed flag and the map of keys in the pressed or long phase. The block
// takes one tick per clock cycle while out_stall does not hold the result; an accepted tick passes through
// the input register, then all key machines update in parallel into the result register.
// Write debounce_ticks (index 0) and long_press_ticks (index 1) only while no tick is in flight.
module keypad_debounce_long_press
  import kpd_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MAP_W-1:0]     in_pressed_map,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_event_kind,
  output logic [IDX_W-1:0]     out_key_num,
  output logic [DUR_W-1:0]     out_duration_ms,
  output logic                 out_any_raw_pressed,
  output logic [MAP_W-1:0]     out_held_map,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // keys at index 16 and up never read pressed, so they are not built
  localparam int NKEYS = ROWS * COLS;
  localparam int NACT  = (NKEYS < MAP_W) ? NKEYS : MAP_W;

  logic [DB_W-1:0]   debounce_ticks_r;
  logic [HOLD_W-1:0] long_press_ticks_r;

  logic              s1_valid_r;
  logic [MAP_W-1:0]  s1_map_r;
  logic [DUR_W-1:0]  tick_r, tick_nxt;

  logic              out_valid_r;
  evt_kind_t         out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [DUR_W-1:0]  out_dur_r, out_dur_nxt;
  logic              out_any_r, out_any_nxt;
  logic [MAP_W-1:0]  out_held_r, out_held_nxt;

  logic              out_free;
  logic              advance;
  logic              in_take;
  logic [DUR_W-1:0]  sel_ticks;

  key_evt_t          evt [NACT];

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign tick_nxt = tick_r + {{(DUR_W-1){1'b0}}, 1'b1};

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= DEBOUNCE_RST;
      long_press_ticks_r <= LONG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_ticks_r   <= cfg_wdata[DB_W-1:0];
        REG_LONG:     long_press_ticks_r <= cfg_wdata[HOLD_W-1:0];
        default:      ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) s1_map_r <= in_pressed_map;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else if (advance) begin
      tick_r <= tick_nxt;
    end
  end

  for (genvar k = 0; k < NACT; k++) begin : g_key
    kpd_key u_key (
      .clk              (clk),
      .rst_n            (rst_n),
      .en               (advance),
      .pressed          (s1_map_r[k]),
      .debounce_ticks   (debounce_ticks_r),
      .long_press_ticks (long_press_ticks_r),
      .tick             (tick_nxt),
      .evt              (evt[k])
    );
  end

  // Highest firing key wins
  always_comb begin
    out_kind_nxt = EV_NONE;
    out_idx_nxt  = '0;
    sel_ticks    = '0;
    out_held_nxt = '0;
    for (int k = 0; k < NACT; k++) begin
      out_held_nxt[k] = evt[k].held;
      if (evt[k].kind != EV_NONE) begin
        out_kind_nxt = evt[k].kind;
        out_idx_nxt  = IDX_W'(k);
        sel_ticks    = evt[k].held_ticks;
      end
    end
    case (out_kind_nxt)
      EV_NONE:    out_dur_nxt = '0;
      EV_PRESS:   out_dur_nxt = '0;
      EV_LONG:    out_dur_nxt = ticks_to_ms(long_press_ticks_r);
      EV_RELEASE: out_dur_nxt = ticks_to_ms(sel_ticks);
      default:    out_dur_nxt = '0;
    endcase
    out_any_nxt = |s1_map_r;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r <= out_kind_nxt;
      out_idx_r  <= out_idx_nxt;
      out_dur_r  <= out_dur_nxt;
      out_any_r  <= out_any_nxt;
      out_held_r <= out_held_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_kind      = out_kind_r;
  assign out_key_num         = out_idx_r;
  assign out_duration_ms     = out_dur_r;
  assign out_any_raw_pressed = out_any_r;
  assign out_held_map        = out_held_r;

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == EV_NONE |-> out_idx_r == '0 && out_dur_r == '0)
    else $error("no-event item carries nonzero index or duration");

  a_press_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == EV_PRESS || out_kind_r == EV_LONG)
      |-> out_held_r[out_idx_r])
    else $error("press or long event from a key not in the held map");

  a_release_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == EV_RELEASE |-> !out_held_r[out_idx_r])
    else $error("release event from a key still held");

  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> tick_r == $past(tick_nxt))
    else $error("tick counter did not step with the item");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

endmodule

@@ test/tb.sv @@
// Testbench for keypad_debounce_long_press: directed and random scan ticks vs. a key predictor.
module tb;
  import kpd_pkg::*;

  localparam int NKEYS       = 16;
  localparam int MS_PER_TICK = 10;
  localparam int MAX_GAP     = 13;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_PRINTED = 20;

  typedef struct {
    evt_kind_t         kind;
    logic [IDX_W-1:0]  key;
    logic [DUR_W-1:0]  dur;
    logic              any_raw;
    logic [MAP_W-1:0]  held;
  } key_event_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [MAP_W-1:0]     in_pressed_map;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           out_event_kind;
  logic [IDX_W-1:0]     out_key_num;
  logic [DUR_W-1:0]     out_duration_ms;
  logic                 out_any_raw_pressed;
  logic [MAP_W-1:0]     out_held_map;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  // Predictor state
  phase_t            key_phase_q [NKEYS];
  logic [DB_W-1:0]   bounce_cnt [NKEYS];
  logic [HOLD_W-1:0] hold_cnt [NKEYS];
  logic [DUR_W-1:0]  press_tick [NKEYS];
  logic [DUR_W-1:0]  scan_ticks;
  logic [DB_W-1:0]   debounce_thr;
  logic [HOLD_W-1:0] long_thr;
  key_event_t        expected_events [$];

  int   mismatches;
  int   quiet_cycles;
  int   rx_hold_cycles;
  bit   tx_idle;
  bit   rx_idle;
  key_event_t want;

  keypad_debounce_long_press dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pressed_map      (in_pressed_map),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_kind      (out_event_kind),
    .out_key_num         (out_key_num),
    .out_duration_ms     (out_duration_ms),
    .out_any_raw_pressed (out_any_raw_pressed),
    .out_held_map        (out_held_map),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic reset_keypad_model();
    debounce_thr = DEBOUNCE_RST;
    long_thr     = LONG_RST;
    scan_ticks   = '0;
    for (int k = 0; k < NKEYS; k++) begin
      key_phase_q[k] = PH_IDLE;
      bounce_cnt[k]  = '0;
      hold_cnt[k]    = '0;
      press_tick[k]  = '0;
    end
  endtask

  // One scan tick: all key machines step, the highest key index with an event wins.
  task automatic scan_keypad(input logic [MAP_W-1:0] map);
    key_event_t ev;
    int c;
    ev.kind    = EV_NONE;
    ev.key     = '0;
    ev.dur     = '0;
    ev.any_raw = (map != '0);
    ev.held    = '0;
    scan_ticks = scan_ticks + 1'b1;
    for (int k = 0; k < NKEYS; k++) begin
      case (key_phase_q[k])
        PH_IDLE: begin
          if (map[k]) begin
            c = int'(bounce_cnt[k]) + 1;
            if (c >= int'(debounce_thr)) begin
              key_phase_q[k] = PH_PRESS;
              bounce_cnt[k]  = '0;
              press_tick[k]  = scan_ticks;
              ev.kind = EV_PRESS;
              ev.key  = IDX_W'(k);
              ev.dur  = '0;
            end else begin
              bounce_cnt[k] = c[DB_W-1:0];
            end
          end else begin
            bounce_cnt[k] = '0;
          end
        end
        PH_PRESS: begin
          if (map[k]) begin
            c = int'(hold_cnt[k]) + 1;
            if (c >= int'(long_thr)) begin
              key_phase_q[k] = PH_LONG;
              hold_cnt[k]    = '0;
              ev.kind = EV_LONG;
              ev.key  = IDX_W'(k);
              ev.dur  = DUR_W'(long_thr * MS_PER_TICK);
            end else begin
              hold_cnt[k] = c[HOLD_W-1:0];
            end
          end else begin
            key_phase_q[k] = PH_RELEASE;
            hold_cnt[k]    = '0;
          end
        end
        PH_LONG: begin
          if (!map[k]) key_phase_q[k] = PH_RELEASE;
        end
        default: begin
          if (!map[k]) begin
            c = int'(bounce_cnt[k]) + 1;
            if (c >= int'(debounce_thr)) begin
              key_phase_q[k] = PH_IDLE;
              bounce_cnt[k]  = '0;
              ev.kind = EV_RELEASE;
              ev.key  = IDX_W'(k);
              ev.dur  = DUR_W'(DUR_W'(scan_ticks - press_tick[k]) * MS_PER_TICK);
            end else begin
              bounce_cnt[k] = c[DB_W-1:0];
            end
          end else begin
            // bounce during release: back to pressed, stamp kept
            bounce_cnt[k]  = '0;
            key_phase_q[k] = PH_PRESS;
          end
        end
      endcase
      if (key_phase_q[k] == PH_PRESS || key_phase_q[k] == PH_LONG) ev.held[k] = 1'b1;
    end
    expected_events.push_back(ev);
  endtask

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] exp_v);
    if (mismatches < MAX_PRINTED)
      $display("mismatch on %s: got %0h, expected %0h at %0t", field, got, exp_v, $time);
    mismatches++;
  endtask

  task automatic send_tick(input logic [MAP_W-1:0] map);
    int gap;
    gap = tx_idle ? $urandom_range(MAX_GAP, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_pressed_map <= map;
    do @(posedge clk); while (in_stall);
    scan_keypad(map);
  endtask

  // Sender holds off until every outstanding result has arrived.
  task automatic pause_ticks();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_DEBOUNCE) debounce_thr = value[DB_W-1:0];
    else long_thr = value[HOLD_W-1:0];
  endtask

  task automatic set_thresholds(input int db, input int lp);
    write_reg(REG_DEBOUNCE, CFG_W'(db));
    write_reg(REG_LONG, CFG_W'(lp));
  endtask

  // Reset thresholds: press and release on key 0 and on key 15, all keys at once.
  task automatic test_reset_values();
    logic [MAP_W-1:0] seq [12] = '{16'h0000, 16'h0001, 16'h0001, 16'h8001, 16'h8000,
                                   16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF,
                                   16'h0000, 16'h0000};
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    foreach (seq[i]) send_tick(seq[i]);
    pause_ticks();
  endtask

  task automatic test_thresholds();
    logic [MAP_W-1:0] zero_seq [4] = '{16'h0010, 16'h0010, 16'h0000, 16'h0000};
    logic [MAP_W-1:0] one_seq [7]  = '{16'h0400, 16'h0400, 16'h0000, 16'h0400, 16'h0400,
                                       16'h0000, 16'h0000};
    set_thresholds(0, 0);
    foreach (zero_seq[i]) send_tick(zero_seq[i]);
    pause_ticks();
    set_thresholds(255, 16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'h0000);
    pause_ticks();
    set_thresholds(1, 1);
    foreach (one_seq[i]) send_tick(one_seq[i]);
    pause_ticks();
  endtask

  // Key 15 held into a long press and released; key 0 tapped so events collide on some ticks.
  task automatic test_long_hold();
    logic [MAP_W-1:0] map;
    set_thresholds(2, 120);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < 150; i++) begin
      map = (i < 140) ? 16'h8000 : 16'h0000;
      if ((i % 10) < 3) map[0] = 1'b1;
      send_tick(map);
    end
    pause_ticks();
  endtask

  task automatic test_backpressure();
    set_thresholds(1, 2);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 80;
    repeat (40) send_tick(MAP_W'($urandom));
    pause_ticks();
  endtask

  // Per phase a few active keys run press/hold/release scripts with occasional chatter.
  task automatic test_random_sequences();
    logic             key_lvl [NKEYS];
    int               key_left [NKEYS];
    logic [MAP_W-1:0] active;
    logic [MAP_W-1:0] map;
    int               db;
    int               lp;
    for (int phase = 0; phase < 12; phase++) begin
      db = ($urandom_range(5, 0) == 0) ? 0 : $urandom_range(4, 1);
      lp = $urandom_range(12, 0);
      set_thresholds(db, lp);
      tx_idle = $urandom_range(1, 0);
      rx_idle = $urandom_range(1, 0);
      active  = MAP_W'($urandom & $urandom) | (MAP_W'(1) << $urandom_range(15, 0));
      for (int k = 0; k < NKEYS; k++) begin
        key_lvl[k]  = 1'b0;
        key_left[k] = 0;
      end
      repeat (100) begin
        if ($urandom_range(9, 0) == 0) begin
          map = MAP_W'($urandom);
        end else begin
          map = '0;
          for (int k = 0; k < NKEYS; k++) begin
            if (active[k]) begin
              if (key_left[k] == 0) begin
                key_lvl[k]  = !key_lvl[k];
                key_left[k] = key_lvl[k] ? $urandom_range(db + lp + 4, 1)
                                         : $urandom_range(db + 3, 1);
              end
              key_left[k]--;
              map[k] = key_lvl[k] ^ ($urandom_range(15, 0) == 0);
            end
          end
        end
        send_tick(map);
      end
      pause_ticks();
    end
  endtask

  // Result side: stall per item, with one long hold-off on request.
  initial begin
    int n;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else begin
        n = rx_idle ? $urandom_range(MAX_GAP, 0) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_events.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        want = expected_events.pop_front();
        if (out_event_kind !== want.kind) report("event_kind", out_event_kind, want.kind);
        if (out_key_num !== want.key) report("key_num", out_key_num, want.key);
        if (out_duration_ms !== want.dur) report("duration_ms", out_duration_ms, want.dur);
        if (out_any_raw_pressed !== want.any_raw)
          report("any_raw_pressed", out_any_raw_pressed, want.any_raw);
        if (out_held_map !== want.held) report("held_map", out_held_map, want.held);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pressed_map <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_wdata      <= '0;
    mismatches     = 0;
    rx_hold_cycles = 0;
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    reset_keypad_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_thresholds();
    test_long_hold();
    test_backpressure();
    test_random_sequences();
    pause_ticks();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
